/* sv/cents_to_hertz_converter_macros.svh */
// Assertion macros shared by the cents to hertz converter RTL.
`ifndef CENTS_TO_HERTZ_CONVERTER_MACROS_SVH
`define CENTS_TO_HERTZ_CONVERTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C2H_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define C2H_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/c2h_pkg.sv */
// Constants, types and ROM-building functions for the cents to hertz converter.
`default_nettype none

package c2h_pkg;

   localparam int C2H_OUT_FRAC_BITS = 16;
   localparam int C2H_ROM_FRAC_BITS = 28;

   localparam int C2H_CENTS_W = 16;
   localparam int C2H_HZ_W    = 47;

   localparam int C2H_ROM_SIZE = 1200;
   localparam int C2H_ADDR_W   = $clog2(C2H_ROM_SIZE);

   // Filter cutoff limits
   localparam logic signed [C2H_CENTS_W-1:0] C2H_FILT_LO = 16'sd1500;
   localparam logic signed [C2H_CENTS_W-1:0] C2H_FILT_HI = 16'sd13500;

   // Cents are offset by 300, then biased by 28 octaves so the dividend is never negative.
   localparam int C2H_OCT_BIAS = 28;
   localparam int C2H_UNUM_W   = 17;
   localparam logic signed [C2H_UNUM_W:0] C2H_UNUM_OFS =
      18'(300 + C2H_OCT_BIAS * C2H_ROM_SIZE);

   // Reciprocal of 1200 with 27 fraction bits; exact quotient for dividends below 125203,
   // which covers every biased value (at most 66667).
   localparam int C2H_RECIP_SH = 27;
   localparam logic [C2H_UNUM_W-1:0] C2H_RECIP =
      17'(((1 << C2H_RECIP_SH) + C2H_ROM_SIZE - 1) / C2H_ROM_SIZE);
   localparam int C2H_PROD_W = 2 * C2H_UNUM_W;
   localparam int C2H_OCT_W  = 6;

   typedef logic [63:0] c2h_mant_table_type [C2H_ROM_SIZE];

   localparam logic [63:0] C2H_Q62_ONE = 64'd1 << 62;

   // Q62 product, truncated.
   function automatic logic [63:0] c2h_qmul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic logic c2h_power_fits(input logic [63:0] s);
      logic [63:0] p;
      p = C2H_Q62_ONE;
      for (int i = 0; i < C2H_ROM_SIZE; i++) begin
         p = c2h_qmul(p, s);
      end
      return p <= (C2H_Q62_ONE << 1);
   endfunction

   // Largest Q62 step whose 1200-fold truncated power stays within 2.0.
   function automatic logic [63:0] c2h_find_step();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = C2H_Q62_ONE;
      hi = C2H_Q62_ONE + (C2H_Q62_ONE >> 10);
      while ((hi - lo) > 64'd1) begin
         mid = lo + ((hi - lo) >> 1);
         if (c2h_power_fits(mid)) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   function automatic c2h_mant_table_type c2h_build_mant(input logic [63:0] step);
      c2h_mant_table_type t;
      logic [63:0] m;
      m = C2H_Q62_ONE;
      for (int r = 0; r < C2H_ROM_SIZE; r++) begin
         t[r] = m;
         m = c2h_qmul(m, step);
      end
      return t;
   endfunction

   localparam logic [63:0]        C2H_STEP = c2h_find_step();
   localparam c2h_mant_table_type C2H_MANT = c2h_build_mant(C2H_STEP);

endpackage

`default_nettype wire

/* sv/c2h_rom.sv */
// 1200-entry exponent ROM, 6.875 * 2^(r/1200), with registered read.
`default_nettype none

module c2h_rom
   import c2h_pkg::*;
#(
   parameter int ROM_FRAC_BITS = C2H_ROM_FRAC_BITS,
   localparam int ENTRY_W = ROM_FRAC_BITS + 4
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [C2H_ADDR_W-1:0] rd_addr,
   output logic      [ENTRY_W-1:0]    rd_data
);

   typedef logic [ENTRY_W-1:0] rom_table_type [C2H_ROM_SIZE];

   // Scale by 6.875 = 55/8 and round to nearest, ties upward.
   function automatic rom_table_type build_rom();
      rom_table_type t;
      logic [63:0] v;
      for (int r = 0; r < C2H_ROM_SIZE; r++) begin
         v = ((C2H_MANT[r] >> 8) * 64'd55) + (64'd1 << (56 - ROM_FRAC_BITS));
         v = v >> (57 - ROM_FRAC_BITS);
         t[r] = v[ENTRY_W-1:0];
      end
      return t;
   endfunction

   localparam rom_table_type ROM_TABLE = build_rom();

   logic [ENTRY_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= ROM_TABLE[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

`default_nettype wire

/* sv/cents_to_hertz_converter.sv */
// Top level: absolute cents to frequency in Hz, five-stage pipeline.
//
//   channel   ports                        direction  transfer
//   request   req_start, req_action/cents  in         start high while busy low
//   response  rsp_strobe, rsp_hertz        out        every cycle strobe is high
//
// One item may enter every cycle; busy stays low. Each result passes through the
// stages in order: clamp and bias, reciprocal multiply, remainder, ROM read,
// shift and saturate. The ROM read port sets the pacing at one lookup a cycle.
// Synchronous reset empties the pipeline; items in flight are dropped.
// The receiver cannot stall, so nothing ever holds the pipeline.
`default_nettype none

`include "cents_to_hertz_converter_macros.svh"

module cents_to_hertz_converter
   import c2h_pkg::*;
#(
   parameter int OUT_FRAC_BITS = C2H_OUT_FRAC_BITS,
   parameter int ROM_FRAC_BITS = C2H_ROM_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_start,
   input  wire logic                          req_action,
   input  wire logic signed [C2H_CENTS_W-1:0] req_cents,
   output logic                               busy,
   output logic                               rsp_strobe,
   output logic             [C2H_HZ_W-1:0]    rsp_hertz
);

   localparam int ENTRY_W = ROM_FRAC_BITS + 4;
   localparam int WIDE_W  = ENTRY_W + C2H_HZ_W;
   localparam int SH_W    = 8;
   localparam int SH_OFF  = OUT_FRAC_BITS - ROM_FRAC_BITS - C2H_OCT_BIAS;

   logic accept;

   // Stage 1: clamp, offset, bias
   logic                          s1_vld_ff;
   logic [C2H_UNUM_W-1:0]         s1_unum_ff;
   logic signed [C2H_CENTS_W-1:0] clamp_cents;
   logic signed [C2H_UNUM_W:0]    unum_sum;

   // Stage 2: octave by reciprocal multiply
   logic                  s2_vld_ff;
   logic [C2H_UNUM_W-1:0] s2_unum_ff;
   logic [C2H_OCT_W-1:0]  s2_oct_ff;
   logic [C2H_PROD_W-1:0] recip_prod;

   // Stage 3: remainder
   logic                  s3_vld_ff;
   logic [C2H_OCT_W-1:0]  s3_oct_ff;
   logic [C2H_ADDR_W-1:0] s3_rem_ff;
   logic [C2H_UNUM_W-1:0] oct_times;
   logic [C2H_UNUM_W-1:0] rem_full;

   // Stage 4: ROM read
   logic                 s4_vld_ff;
   logic [C2H_OCT_W-1:0] s4_oct_ff;
   logic [ENTRY_W-1:0]   rom_data;

   // Stage 5: shift and saturate
   logic                      s5_vld_ff;
   logic [C2H_HZ_W-1:0]       s5_hz_ff;
   logic signed [SH_W-1:0]    shift_amt;
   logic [SH_W-1:0]           shift_mag;
   logic                      shift_neg;
   logic [WIDE_W-1:0]         entry_wide;
   logic [WIDE_W-1:0]         shifted;
   logic                      sat;
   logic [C2H_HZ_W-1:0]       hz_in;

   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   always_comb begin
      clamp_cents = req_cents;
      if (req_action) begin
         if (req_cents >= C2H_FILT_HI) begin
            clamp_cents = C2H_FILT_HI;
         end else if (req_cents < C2H_FILT_LO) begin
            clamp_cents = C2H_FILT_LO;
         end
      end
      unum_sum = (C2H_UNUM_W+1)'(clamp_cents) + C2H_UNUM_OFS;
   end

   assign recip_prod = {{C2H_UNUM_W{1'b0}}, s1_unum_ff} * {{C2H_UNUM_W{1'b0}}, C2H_RECIP};

   // Octave times 1200 as shifts: 1024 + 128 + 32 + 16
   always_comb begin
      oct_times = (C2H_UNUM_W'(s2_oct_ff) << 10) + (C2H_UNUM_W'(s2_oct_ff) << 7)
                + (C2H_UNUM_W'(s2_oct_ff) << 5) + (C2H_UNUM_W'(s2_oct_ff) << 4);
      rem_full  = s2_unum_ff - oct_times;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_unum_ff <= unum_sum[C2H_UNUM_W-1:0];
      s2_unum_ff <= s1_unum_ff;
      s2_oct_ff  <= recip_prod[C2H_RECIP_SH +: C2H_OCT_W];
      s3_oct_ff  <= s2_oct_ff;
      s3_rem_ff  <= rem_full[C2H_ADDR_W-1:0];
      s4_oct_ff  <= s3_oct_ff;
      s5_hz_ff   <= hz_in;
   end

   c2h_rom #(
      .ROM_FRAC_BITS (ROM_FRAC_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (s3_vld_ff),
      .rd_addr (s3_rem_ff),
      .rd_data (rom_data)
   );

   // Net shift: octave less bias, plus the change in fraction bits
   always_comb begin
      shift_amt  = $signed(SH_W'(s4_oct_ff)) + SH_W'(SH_OFF);
      shift_neg  = shift_amt[SH_W-1];
      shift_mag  = shift_neg ? SH_W'(-shift_amt) : SH_W'(shift_amt);
      entry_wide = WIDE_W'(rom_data);
      shifted    = shift_neg ? (entry_wide >> shift_mag) : (entry_wide << shift_mag);
      sat        = !shift_neg && ((shift_mag >= SH_W'(C2H_HZ_W))
                                  || (|shifted[WIDE_W-1:C2H_HZ_W]));
      hz_in      = sat ? {C2H_HZ_W{1'b1}} : shifted[C2H_HZ_W-1:0];
   end

   assign rsp_strobe = s5_vld_ff;
   assign rsp_hertz  = s5_hz_ff;

   `C2H_ASSERT_IMP(a_strobe_has_request, clock, reset, rsp_strobe, $past(req_start, 5), "result without a request")
   `C2H_ASSERT_NXT(a_valid_chain, clock, reset, s2_vld_ff, s3_vld_ff, "item lost between stages")
   `C2H_ASSERT_IMP(a_rem_in_range, clock, reset, s3_vld_ff, s3_rem_ff < C2H_ADDR_W'(C2H_ROM_SIZE), "remainder beyond table")
   `C2H_ASSERT_IMP(a_filter_nonzero, clock, reset, rsp_strobe && $past(req_action, 5), rsp_hertz != '0, "filter result underflowed")

endmodule

`default_nettype wire

/* dv/tb_cents_to_hertz_converter.sv */
// Testbench for the cents to hertz converter: directed and random conversions against a predictor.
`timescale 1ns / 1ps

module tb_cents_to_hertz_converter
   import c2h_pkg::*;
();

   localparam int CENTS_PER_OCTAVE = 1200;
   localparam int PITCH_OFFSET     = 300;
   localparam int CUTOFF_LO        = 1500;
   localparam int CUTOFF_HI        = 13500;
   localparam int OUT_FRAC         = C2H_OUT_FRAC_BITS;
   localparam int ROM_FRAC         = C2H_ROM_FRAC_BITS;
   localparam logic [63:0] Q62_UNIT = 64'd1 << 62;
   localparam logic [63:0] HERTZ_SAT = (64'd1 << C2H_HZ_W) - 64'd1;

   localparam logic MODE_RAW    = 1'b0;
   localparam logic MODE_CUTOFF = 1'b1;

   localparam int RANDOM_ITEMS   = 800;
   localparam int STALL_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 12;
   localparam int MAX_ERR_LINES  = 40;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_start = 1'b0;
   logic                            req_action = MODE_RAW;
   logic signed [C2H_CENTS_W-1:0]   req_cents = '0;
   logic                            busy;
   logic                            rsp_strobe;
   logic [C2H_HZ_W-1:0]             rsp_hertz;

   logic [63:0]          exp2_rom [CENTS_PER_OCTAVE];
   logic [C2H_HZ_W-1:0]  hertz_due [$];
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;
   logic                 no_idle = 1'b0;
   logic                 moved;
   logic [C2H_HZ_W-1:0]  hertz_want;

   cents_to_hertz_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_action (req_action),
      .req_cents  (req_cents),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_hertz  (rsp_hertz)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Q62 fixed-point product, fraction truncated.
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return 64'(full >> 62);
   endfunction

   // Fill the mantissa table: 6.875 * 2^(r/1200), rounded, from a chained Q62 step.
   task automatic build_exp2_rom();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] acc;
      lo = Q62_UNIT;
      hi = Q62_UNIT + (Q62_UNIT >> 10);
      while (hi - lo > 64'd1) begin
         mid = lo + (hi - lo) / 64'd2;
         acc = Q62_UNIT;
         for (int i = 0; i < CENTS_PER_OCTAVE; i++) acc = q62_mul(acc, mid);
         if (acc <= (Q62_UNIT << 1)) lo = mid;
         else hi = mid;
      end
      acc = Q62_UNIT;
      for (int r = 0; r < CENTS_PER_OCTAVE; r++) begin
         exp2_rom[r] = (((acc >> 8) * 64'd55) + (64'd1 << (56 - ROM_FRAC))) >> (57 - ROM_FRAC);
         acc = q62_mul(acc, lo);
      end
   endtask

   function automatic logic [C2H_HZ_W-1:0] predict_hertz(input logic mode,
                                                         input logic signed [15:0] cents);
      int c;
      int t;
      int oct;
      int rem;
      int sh;
      logic [63:0] mant;
      logic [63:0] hz;
      c = int'(cents);
      if (mode == MODE_CUTOFF) begin
         if (c >= CUTOFF_HI) c = CUTOFF_HI;
         else if (c < CUTOFF_LO) c = CUTOFF_LO;
      end
      t = c + PITCH_OFFSET;
      oct = t / CENTS_PER_OCTAVE;
      rem = t % CENTS_PER_OCTAVE;
      // floor division, not truncation
      if (rem < 0) begin
         rem += CENTS_PER_OCTAVE;
         oct -= 1;
      end
      mant = exp2_rom[rem];
      sh = oct + OUT_FRAC - ROM_FRAC;
      if (sh >= 0) begin
         if (sh >= C2H_HZ_W || mant > (HERTZ_SAT >> sh)) hz = HERTZ_SAT;
         else hz = mant << sh;
      end else begin
         hz = (-sh >= 64) ? 64'd0 : (mant >> -sh);
         if (hz > HERTZ_SAT) hz = HERTZ_SAT;
      end
      return hz[C2H_HZ_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [C2H_HZ_W-1:0] got,
                                  input logic [C2H_HZ_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_ERR_LINES)
         $display("%0t: %s: hertz got %h want %h", $realtime, what, got, want);
   endtask

   // Score every transfer on both channels; predict at request, compare at response.
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_strobe === 1'b1) begin
            moved = 1'b1;
            if (hertz_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_hertz, '0);
            end else begin
               hertz_want = hertz_due.pop_front();
               if (rsp_hertz !== hertz_want) report_mismatch("wrong result", rsp_hertz, hertz_want);
            end
         end
         if (req_start && busy === 1'b0) begin
            moved = 1'b1;
            hertz_due.push_back(predict_hertz(req_action, req_cents));
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb_cents_to_hertz_converter: done, errors");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (no_idle || roll < 50) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Hold start until the transfer, then idle for the chosen gap.
   task automatic send_item(input logic mode, input logic signed [15:0] cents);
      int gap;
      req_start <= 1'b1;
      req_action <= mode;
      req_cents <= cents;
      do @(posedge clock); while (busy !== 1'b0);
      gap = pick_gap();
      if (gap > 0) begin
         req_start <= 1'b0;
         req_action <= 1'($urandom_range(1));
         req_cents <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_start <= 1'b0;
      while (hertz_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_item(MODE_RAW, -16'sd32768);
      send_item(MODE_RAW, 16'sd32767);
      send_item(MODE_CUTOFF, -16'sd32768);
      send_item(MODE_CUTOFF, 16'sd32767);
      send_item(MODE_RAW, 16'sd0);
      send_item(MODE_RAW, -16'sd1);
      send_item(MODE_RAW, 16'sd6900);
   endtask

   task automatic test_filter_clamp();
      send_item(MODE_CUTOFF, 16'sd1499);
      send_item(MODE_CUTOFF, 16'sd1500);
      send_item(MODE_CUTOFF, 16'sd1501);
      send_item(MODE_CUTOFF, 16'sd13499);
      send_item(MODE_CUTOFF, 16'sd13500);
      send_item(MODE_CUTOFF, 16'sd13501);
      send_item(MODE_RAW, 16'sd1499);
      send_item(MODE_RAW, 16'sd13501);
   endtask

   // Remainder wrap on both sides of zero, down to the deepest underflow.
   task automatic test_octave_edges();
      send_item(MODE_RAW, 16'sd900);
      send_item(MODE_RAW, 16'sd899);
      send_item(MODE_RAW, -16'sd300);
      send_item(MODE_RAW, -16'sd301);
      send_item(MODE_RAW, -16'sd32700);
      send_item(MODE_RAW, -16'sd32701);
   endtask

   task automatic test_drain_pause();
      no_idle = 1'b1;
      repeat (6) send_item(1'($urandom_range(1)), 16'($urandom));
      no_idle = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_mix();
      int kind;
      int k;
      int value;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(39) == 0) no_idle = ~no_idle;
         kind = $urandom_range(99);
         if (kind < 50) begin
            value = $urandom_range(65535);
         end else if (kind < 70) begin
            value = ($urandom_range(1) ? CUTOFF_LO : CUTOFF_HI) + $urandom_range(16);
            value -= 8;
         end else if (kind < 90) begin
            k = $urandom_range(54);
            k -= 27;
            value = k * CENTS_PER_OCTAVE - PITCH_OFFSET + $urandom_range(6);
            value -= 3;
         end else begin
            value = $urandom_range(1) ? 32767 : -32768;
         end
         send_item(1'($urandom_range(1)), 16'(value));
         if ($urandom_range(99) == 0) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      build_exp2_rom();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_filter_clamp();
      test_octave_edges();
      test_drain_pause();
      test_random_mix();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (hertz_due.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d results never arrived", $realtime, hertz_due.size());
      end
      if (mismatch_count == 0) begin
         $display("tb_cents_to_hertz_converter: done, clean");
      end else begin
         $display("tb_cents_to_hertz_converter: done, errors");
      end
      $finish;
   end

endmodule
